@@ hw/rtl/chs_pkg.sv @@
`default_nettype none

package chs_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int HANDLE_W        = 32;
    localparam int SLOT_W          = 4;
    localparam int ENTRY_COUNT_W   = 5;

    typedef enum logic [2:0] {
        MODE_TRACK   = 3'd0,
        MODE_UNTRACK = 3'd1,
        MODE_RELEASE = 3'd2,
        MODE_CLEAR   = 3'd3,
        MODE_GET     = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_NULL     = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_DUP      = 3'd3,
        STAT_NOTFOUND = 3'd4,
        STAT_RANGE    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_GET,
        S_REL_RD,
        S_REL_LD,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [2:0]             mode;
        logic [HANDLE_W-1:0]    handle;
        logic [SLOT_W-1:0]      slot_index;
        logic [HANDLE_W-1:0]    owner_id;
    } req_t;

    typedef struct packed {
        logic [2:0]               status;
        logic [HANDLE_W-1:0]      handle_out;
        logic [HANDLE_W-1:0]      release_owner;
        logic [ENTRY_COUNT_W-1:0] entry_count;
        logic                     last;
    } rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/chs_req_if.sv @@
`default_nettype none

interface chs_req_if;
    logic           valid;
    logic           ready;
    chs_pkg::req_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/chs_rsp_if.sv @@
`default_nettype none

interface chs_rsp_if;
    logic           valid;
    logic           ready;
    chs_pkg::rsp_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/compacting_handle_set.sv @@
// Steps from acceptance to first result item: clear, null/full/range refusals and unused
//   modes pass through S_RESP; get reads the table in S_GET first; track scans one entry per
//   cycle and stops at a duplicate; untrack scans, then shifts later entries down one per cycle.
// Force release: each item is read in S_REL_RD, then loaded into the output register in S_REL_LD.
// Throughput: one input item at a time; the next is taken once the sequencer is idle again.
// Reset (async, rst_n low) empties the list and drops any pending result; table not swept.
`default_nettype none

module compacting_handle_set #(
    parameter int TABLE_DEPTH = chs_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    chs_req_if.sink    req,
    chs_rsp_if.source  rsp
);

    // count width holds the depth itself; address width indexes the table
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int HW = chs_pkg::HANDLE_W;

    // handle table: one write port, one registered read port
    logic [HW-1:0] mem [TABLE_DEPTH];
    logic [HW-1:0] rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [HW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // sequencer state
    chs_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    ptr_reg, ptr_next;      // next entry to read
    logic [AW-1:0]    pos_reg, pos_next;      // address of pending read / shift write
    logic             pend_reg, pend_next;    // read data arrives this cycle
    logic [2:0]       op_reg, op_next;
    logic [HW-1:0]    key_reg, key_next;
    logic [HW-1:0]    owner_reg, owner_next;
    chs_pkg::status_t status_reg, status_next;
    logic [HW-1:0]    hout_reg, hout_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    chs_pkg::rsp_t    out_data_reg, out_data_next;

    logic slot_free;
    logic hit;
    logic in_fire;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign hit       = pend_reg && (rdata_reg == key_reg);
    assign in_fire   = req.valid && req.ready;

    assign req.ready   = (state_reg == chs_pkg::S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= chs_pkg::S_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        op_reg       <= op_next;
        key_reg      <= key_next;
        owner_reg    <= owner_next;
        status_reg   <= status_next;
        hout_reg     <= hout_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        pend_next      = pend_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        owner_next     = owner_reg;
        status_next    = status_reg;
        hout_next      = hout_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg;
        mem_wdata      = rdata_reg;
        mem_re         = 1'b0;
        mem_raddr      = AW'(ptr_reg);

        unique case (state_reg)
            chs_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next     = req.payload.mode;
                    key_next    = req.payload.handle;
                    owner_next  = req.payload.owner_id;
                    ptr_next    = '0;
                    pend_next   = 1'b0;
                    status_next = chs_pkg::STAT_OK;
                    hout_next   = '0;
                    state_next  = chs_pkg::S_RESP;
                    unique case (req.payload.mode)
                        chs_pkg::MODE_TRACK:
                        begin
                            if (req.payload.handle == '0)
                            begin
                                status_next = chs_pkg::STAT_NULL;
                            end
                            else if (count_reg == CW'(TABLE_DEPTH))
                            begin
                                status_next = chs_pkg::STAT_FULL;
                            end
                            else
                            begin
                                state_next = chs_pkg::S_SCAN;
                            end
                        end
                        chs_pkg::MODE_UNTRACK:
                        begin
                            if (req.payload.handle == '0)
                            begin
                                status_next = chs_pkg::STAT_NULL;
                            end
                            else
                            begin
                                state_next = chs_pkg::S_SCAN;
                            end
                        end
                        chs_pkg::MODE_RELEASE:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = chs_pkg::S_REL_RD;
                            end
                        end
                        chs_pkg::MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        chs_pkg::MODE_GET:
                        begin
                            if (32'(req.payload.slot_index) < 32'(count_reg))
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(req.payload.slot_index);
                                state_next = chs_pkg::S_GET;
                            end
                            else
                            begin
                                status_next = chs_pkg::STAT_RANGE;
                            end
                        end
                        default:
                        begin
                            // unused mode: plain ok with current count
                        end
                    endcase
                end
            end

            chs_pkg::S_SCAN:
            begin
                priority if (hit)
                begin
                    if (op_reg == chs_pkg::MODE_TRACK)
                    begin
                        status_next = chs_pkg::STAT_DUP;
                        state_next  = chs_pkg::S_RESP;
                    end
                    else
                    begin
                        // found at pos_reg: shift later entries down
                        ptr_next   = CW'(pos_reg) + CW'(1);
                        pend_next  = 1'b0;
                        state_next = chs_pkg::S_SHIFT;
                    end
                end
                else if (ptr_reg < count_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(ptr_reg);
                    pos_next  = AW'(ptr_reg);
                    ptr_next  = ptr_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = chs_pkg::S_RESP;
                    if (op_reg == chs_pkg::MODE_TRACK)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = AW'(count_reg);
                        mem_wdata  = key_reg;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        status_next = chs_pkg::STAT_NOTFOUND;
                    end
                end
            end

            chs_pkg::S_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_reg;
                    mem_wdata = rdata_reg;
                    pos_next  = pos_reg + AW'(1);
                end
                if (ptr_reg < count_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(ptr_reg);
                    ptr_next  = ptr_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = chs_pkg::S_RESP;
                    end
                end
            end

            chs_pkg::S_GET:
            begin
                hout_next  = rdata_reg;
                state_next = chs_pkg::S_RESP;
            end

            chs_pkg::S_REL_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(ptr_reg);
                state_next = chs_pkg::S_REL_LD;
            end

            chs_pkg::S_REL_LD:
            begin
                if (slot_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.status        = chs_pkg::STAT_OK;
                    out_data_next.handle_out    = rdata_reg;
                    out_data_next.release_owner = owner_reg;
                    out_data_next.entry_count   = '0;
                    out_data_next.last          = ((ptr_reg + CW'(1)) == count_reg);
                    ptr_next                    = ptr_reg + CW'(1);
                    if ((ptr_reg + CW'(1)) == count_reg)
                    begin
                        count_next = '0;
                        state_next = chs_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = chs_pkg::S_REL_RD;
                    end
                end
            end

            chs_pkg::S_RESP:
            begin
                if (slot_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.status        = status_reg;
                    out_data_next.handle_out    = hout_reg;
                    out_data_next.release_owner = '0;
                    out_data_next.entry_count   = chs_pkg::ENTRY_COUNT_W'(count_reg);
                    out_data_next.last          = 1'b1;
                    state_next                  = chs_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = chs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/chs_checker.sv @@
`default_nettype none

module chs_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 req_valid,
    input wire logic                                 req_ready,
    input wire logic                                 rsp_valid,
    input wire logic                                 rsp_ready,
    input wire logic [2:0]                           status,
    input wire logic [chs_pkg::HANDLE_W-1:0]         handle_out,
    input wire logic [chs_pkg::HANDLE_W-1:0]         release_owner,
    input wire logic [chs_pkg::ENTRY_COUNT_W-1:0]    entry_count,
    input wire logic                                 last
);

    // the block is busy in the cycle after it accepts an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("ready held right after an accepted item");

    // refusals are always single, final items
    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status != chs_pkg::STAT_OK) |-> last)
        else $error("error status on a non-final item");

    // only releases come in groups: non-final items carry a real handle, empty list
    a_nonlast_release: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !last) |-> (handle_out != '0 && entry_count == '0
                                  && status == chs_pkg::STAT_OK))
        else $error("non-final item that is not a release");

    // owner only appears on releases
    a_owner_release: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && release_owner != '0) |-> (status == chs_pkg::STAT_OK
                                                && entry_count == '0))
        else $error("owner id on a non-release item");

    // out-of-range get returns no handle
    a_range_null: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_ready && status == chs_pkg::STAT_RANGE) |-> handle_out == '0)
        else $error("handle returned with range error");

endmodule

bind compacting_handle_set chs_checker u_chs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.payload.status),
    .handle_out    (rsp.payload.handle_out),
    .release_owner (rsp.payload.release_owner),
    .entry_count   (rsp.payload.entry_count),
    .last          (rsp.payload.last)
);

`default_nettype wire

@@ sim/handle_set_checker.sv @@
`timescale 1ns / 100ps

module handle_set_checker (
    input  logic  clk,
    input  logic  rst_n,
    chs_req_if    req,
    chs_rsp_if    rsp,
    output int    fail_count,
    output int    pending
);

    localparam int DEPTH = chs_pkg::TABLE_DEPTH_DEF;

    // Shadow copy of the list.
    logic [chs_pkg::HANDLE_W-1:0] held_handles [DEPTH];
    int                           held_count;

    chs_pkg::rsp_t pending_results [$];
    int            mismatches;

    function automatic void push_result(logic [2:0] status,
                                        logic [chs_pkg::HANDLE_W-1:0] hout,
                                        logic [chs_pkg::HANDLE_W-1:0] owner, logic last);
        chs_pkg::rsp_t r;
        r.status        = status;
        r.handle_out    = hout;
        r.release_owner = owner;
        r.entry_count   = chs_pkg::ENTRY_COUNT_W'(held_count);
        r.last          = last;
        pending_results.push_back(r);
    endfunction

    function automatic int find_handle(logic [chs_pkg::HANDLE_W-1:0] h);
        for (int i = 0; i < held_count; i++)
        begin
            if (held_handles[i] == h)
                return i;
        end
        return -1;
    endfunction

    // Apply one request to the shadow list and queue its results.
    function automatic void apply_request(chs_pkg::req_t r);
        logic [2:0] status;
        logic [chs_pkg::HANDLE_W-1:0] hout;
        int pos;
        int n;
        status = chs_pkg::STAT_OK;
        hout   = '0;
        case (r.mode)
            chs_pkg::MODE_TRACK:
            begin
                if (r.handle == '0)
                    status = chs_pkg::STAT_NULL;
                else if (held_count >= DEPTH)
                    status = chs_pkg::STAT_FULL;
                else if (find_handle(r.handle) >= 0)
                    status = chs_pkg::STAT_DUP;
                else
                begin
                    held_handles[held_count] = r.handle;
                    held_count++;
                end
            end
            chs_pkg::MODE_UNTRACK:
            begin
                if (r.handle == '0)
                    status = chs_pkg::STAT_NULL;
                else
                begin
                    pos = find_handle(r.handle);
                    if (pos < 0)
                        status = chs_pkg::STAT_NOTFOUND;
                    else
                    begin
                        for (int i = pos; i + 1 < held_count; i++)
                            held_handles[i] = held_handles[i + 1];
                        held_count--;
                        held_handles[held_count] = '0;
                    end
                end
            end
            chs_pkg::MODE_RELEASE:
            begin
                n = held_count;
                held_count = 0;
                if (n == 0)
                    push_result(chs_pkg::STAT_OK, '0, '0, 1'b1);
                for (int i = 0; i < n; i++)
                begin
                    push_result(chs_pkg::STAT_OK, held_handles[i], r.owner_id, i == n - 1);
                    held_handles[i] = '0;
                end
                return;
            end
            chs_pkg::MODE_CLEAR:
            begin
                for (int i = 0; i < DEPTH; i++)
                    held_handles[i] = '0;
                held_count = 0;
            end
            chs_pkg::MODE_GET:
            begin
                if (int'(r.slot_index) >= held_count)
                    status = chs_pkg::STAT_RANGE;
                else
                    hout = held_handles[r.slot_index];
            end
            default: ;
        endcase
        push_result(status, hout, '0, 1'b1);
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        chs_pkg::rsp_t want;
        chs_pkg::rsp_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                held_handles[i] = '0;
            held_count = 0;
            pending_results.delete();
        end
        else
        begin
            // Compare first: a result never belongs to a request taken on the same edge.
            if (rsp.valid && rsp.ready)
            begin
                got = rsp.payload;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected item, status %0d handle %0h owner %0h count %0d",
                             $time, got.status, got.handle_out, got.release_owner,
                             got.entry_count);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("status", 32'(want.status), 32'(got.status));
                    compare_field("handle_out", want.handle_out, got.handle_out);
                    compare_field("release_owner", want.release_owner, got.release_owner);
                    compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
                    compare_field("last", 32'(want.last), 32'(got.last));
                end
            end
            if (req.valid && req.ready)
                apply_request(req.payload);
        end
        fail_count <= mismatches;
        pending    <= pending_results.size();
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    // Mode codes the block must ignore.
    localparam logic [2:0] MODE_RSVD_A = 3'd5;
    localparam logic [2:0] MODE_RSVD_B = 3'd6;
    localparam logic [2:0] MODE_RSVD_C = 3'd7;

    localparam int POOL_SIZE   = 24;    // more than the table holds, so it fills up
    localparam int RANDOM_ITEMS = 400;

    logic clk;
    logic rst_n;
    logic calm;     // no idling on either side while set
    int   fail_count;
    int   pending;

    logic [chs_pkg::HANDLE_W-1:0] handle_pool [POOL_SIZE];

    chs_req_if req_ch ();
    chs_rsp_if rsp_ch ();

    compacting_handle_set u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    handle_set_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Hard stop in case the block hangs.
    initial
    begin
        #1000000;
        $display("testbench failed");
        $finish;
    end

    // Result side: drop ready about 31 times in a hundred while not calm.
    always @(posedge clk)
        rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 31);

    function automatic logic [chs_pkg::HANDLE_W-1:0] fresh_handle();
        logic [chs_pkg::HANDLE_W-1:0] v;
        v = $urandom();
        if (v == '0)
            v = 1;
        return v;
    endfunction

    // Offer one request, with random idle cycles ahead of it, and hold it until taken.
    task automatic issue_request(input logic [2:0] mode,
                                 input logic [chs_pkg::HANDLE_W-1:0] handle,
                                 input logic [chs_pkg::SLOT_W-1:0] slot,
                                 input logic [chs_pkg::HANDLE_W-1:0] owner);
        chs_pkg::req_t r;
        r.mode       = mode;
        r.handle     = handle;
        r.slot_index = slot;
        r.owner_id   = owner;
        while (!calm && $urandom_range(0, 99) < 31)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    initial
    begin
        logic [2:0]                   mode;
        logic [chs_pkg::HANDLE_W-1:0] h;
        int                           pick;

        rst_n          <= 1'b0;
        calm           <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        for (int i = 0; i < POOL_SIZE; i++)
            handle_pool[i] = fresh_handle();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list: get out of range, release gives one empty item.
        issue_request(chs_pkg::MODE_GET, '0, '0, '0);
        issue_request(chs_pkg::MODE_RELEASE, '0, '0, 32'h1234_5678);
        // Null and absent untrack, null track.
        issue_request(chs_pkg::MODE_UNTRACK, '0, '0, '0);
        issue_request(chs_pkg::MODE_UNTRACK, 32'hDEAD_BEEF, '0, '0);
        issue_request(chs_pkg::MODE_TRACK, '0, '0, '0);
        // All-ones handle, then its duplicate.
        issue_request(chs_pkg::MODE_TRACK, 32'hFFFF_FFFF, '0, '0);
        issue_request(chs_pkg::MODE_TRACK, 32'hFFFF_FFFF, '0, '0);
        issue_request(chs_pkg::MODE_GET, '0, 4'd0, '0);
        issue_request(chs_pkg::MODE_GET, '0, 4'd15, '0);
        // Ignored modes.
        issue_request(MODE_RSVD_A, 32'h0000_0001, 4'd3, 32'hFFFF_FFFF);
        issue_request(MODE_RSVD_B, 32'h0000_0001, 4'd3, 32'hFFFF_FFFF);
        issue_request(MODE_RSVD_C, 32'h0000_0001, 4'd3, 32'hFFFF_FFFF);
        // Fill to capacity.
        for (int i = 1; i < chs_pkg::TABLE_DEPTH_DEF; i++)
            issue_request(chs_pkg::MODE_TRACK, i * 32'h1000_0001, '0, '0);
        // Full list: full wins over duplicate, null wins over full.
        issue_request(chs_pkg::MODE_TRACK, 32'h5A5A_5A5A, '0, '0);
        issue_request(chs_pkg::MODE_TRACK, '0, '0, '0);
        issue_request(chs_pkg::MODE_TRACK, 32'hFFFF_FFFF, '0, '0);
        issue_request(chs_pkg::MODE_GET, '0, 4'd15, '0);
        // Untrack from the middle, the front and the back.
        issue_request(chs_pkg::MODE_UNTRACK, 32'h3000_0003, '0, '0);
        issue_request(chs_pkg::MODE_UNTRACK, 32'hFFFF_FFFF, '0, '0);
        issue_request(chs_pkg::MODE_UNTRACK, 32'hF000_000F, '0, '0);
        issue_request(chs_pkg::MODE_RELEASE, '0, '0, 32'hFFFF_FFFF);
        issue_request(chs_pkg::MODE_TRACK, 32'h8000_0000, '0, '0);
        issue_request(chs_pkg::MODE_CLEAR, '0, '0, '0);
        issue_request(chs_pkg::MODE_GET, '0, 4'd0, '0);

        // Random part: handles mostly from a small pool so hits and duplicates are common.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm <= (n >= 180 && n < 260);
            if ($urandom_range(0, 9) == 0)
                handle_pool[$urandom_range(0, POOL_SIZE - 1)] = fresh_handle();
            h = handle_pool[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 19) == 0)
                h = '0;
            pick = $urandom_range(0, 99);
            if (pick < 44)
                mode = chs_pkg::MODE_TRACK;
            else if (pick < 68)
            begin
                mode = chs_pkg::MODE_UNTRACK;
                if ($urandom_range(0, 9) == 0)
                    h = $urandom();
            end
            else if (pick < 84)
                mode = chs_pkg::MODE_GET;
            else if (pick < 90)
                mode = chs_pkg::MODE_RELEASE;
            else if (pick < 93)
                mode = chs_pkg::MODE_CLEAR;
            else if (pick < 95)
                mode = MODE_RSVD_A;
            else if (pick < 97)
                mode = MODE_RSVD_B;
            else
                mode = MODE_RSVD_C;
            issue_request(mode, h, 4'($urandom_range(0, 15)), $urandom());
        end
        req_ch.valid <= 1'b0;
        calm         <= 1'b0;

        // Let the checker see the last request, then drain.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
